/* design/fla_pkg.sv */
package fla_pkg;

    localparam int DEF_MODEL_IDS = 64;

    localparam int FREE_ID_W  = 12;
    localparam int STATUS_W   = 2;
    localparam int GRANTED_W  = 6;
    localparam int COUNT_W    = 7;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_DECIDE
    } state_t;

    typedef struct packed {
        logic init_wr;
        logic latch;
        logic decide;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
    } ctrl_sts_t;

endpackage

/* design/fla_ram.sv */
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/fla_ctrl.sv */
module fla_ctrl
    import fla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_IDLE;
            default:  state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_INIT:   cmd.init_wr = 1'b1;
            S_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            S_READ:   busy = 1'b1;
            S_DECIDE: cmd.decide = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

endmodule

/* design/fla_datapath.sv */
module fla_datapath
    import fla_pkg::*;
#(
    parameter int MODEL_IDS = DEF_MODEL_IDS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output ctrl_sts_t            sts,
    input  logic                 req_type,
    input  logic [FREE_ID_W-1:0] free_id,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [GRANTED_W-1:0] granted_id,
    output logic [COUNT_W-1:0]   free_count
);

    localparam int ID_W  = $clog2(MODEL_IDS);
    localparam int CNT_W = $clog2(MODEL_IDS + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [ID_W-1:0]      init_idx_reg;
    logic                 req_reg;
    logic [FREE_ID_W-1:0] id_reg;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [GRANTED_W-1:0] granted_reg;
    logic [GRANTED_W-1:0] granted_next;
    logic [COUNT_W-1:0]   free_count_reg;

    logic [CNT_W-1:0]     count_dec;
    logic [CNT_W-1:0]     count_inc;
    logic [31:0]          id_wide;
    logic [31:0]          got_wide;
    logic [31:0]          count_wide;
    logic                 in_range;
    logic                 count_full;

    logic                 stk_we;
    logic [ID_W-1:0]      stk_waddr;
    logic [ID_W-1:0]      stk_wdata;
    logic [ID_W-1:0]      stk_raddr;
    logic [ID_W-1:0]      stk_rdata;
    logic                 fre_we;
    logic [ID_W-1:0]      fre_waddr;
    logic                 fre_wdata;
    logic                 fre_rdata;

    // The stack and the free flags are filled by a pass after reset.
    fla_ram #(.WIDTH(ID_W), .DEPTH(MODEL_IDS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    fla_ram #(.WIDTH(1), .DEPTH(MODEL_IDS)) u_free_ram (
        .clk   (clk),
        .we    (fre_we),
        .waddr (fre_waddr),
        .wdata (fre_wdata),
        .raddr (id_reg[ID_W-1:0]),
        .rdata (fre_rdata)
    );

    assign count_dec  = count_reg - CNT_W'(1);
    assign count_inc  = count_reg + CNT_W'(1);
    assign stk_raddr  = count_dec[ID_W-1:0];
    assign id_wide    = 32'(id_reg);
    assign got_wide   = 32'(stk_rdata);
    assign in_range   = id_wide < 32'(MODEL_IDS);
    assign count_full = count_reg >= CNT_W'(MODEL_IDS);
    assign count_wide = 32'(count_next);

    assign sts.init_last = init_idx_reg == ID_W'(MODEL_IDS - 1);

    always_comb
    begin
        count_next   = count_reg;
        status_next  = ST_OK;
        granted_next = '0;
        stk_we       = 1'b0;
        stk_waddr    = init_idx_reg;
        stk_wdata    = init_idx_reg;
        fre_we       = 1'b0;
        fre_waddr    = init_idx_reg;
        fre_wdata    = 1'b1;
        if (cmd.init_wr)
        begin
            stk_we = 1'b1;
            fre_we = 1'b1;
        end
        else if (cmd.decide)
        begin
            if (req_reg == REQ_ALLOC)
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next   = count_dec;
                    granted_next = got_wide[GRANTED_W-1:0];
                    fre_we       = 1'b1;
                    fre_waddr    = stk_rdata;
                    fre_wdata    = 1'b0;
                end
            end
            else if (!in_range)
            begin
                status_next = ST_RANGE;
            end
            else if (fre_rdata || count_full)
            begin
                status_next = ST_DOUBLE;
            end
            else
            begin
                count_next = count_inc;
                stk_we     = 1'b1;
                stk_waddr  = count_reg[ID_W-1:0];
                stk_wdata  = id_reg[ID_W-1:0];
                fre_we     = 1'b1;
                fre_waddr  = id_reg[ID_W-1:0];
                fre_wdata  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= CNT_W'(MODEL_IDS);
            init_idx_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.decide;
            if (cmd.init_wr)
            begin
                init_idx_reg <= init_idx_reg + ID_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            id_reg  <= free_id;
        end
        if (cmd.decide)
        begin
            status_reg     <= status_next;
            granted_reg    <= granted_next;
            free_count_reg <= count_wide[COUNT_W-1:0];
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;
    assign free_count = free_count_reg;

endmodule

/* design/model_id_free_list_allocator_top.sv */
// LIFO identifier allocator: one request per item, one result per request.
// The result strobe rises after the registered stack and free-flag read in the read state,
// then the decision into the output registers in the decide state.
// A new item is taken only in the idle state, once the read and decide states of the last are done.
// Reset: a fill pass writes every stack entry and free flag with busy high;
// results are strobed and the receiver cannot stall.
module model_id_free_list_allocator_top
    import fla_pkg::*;
#(
    parameter int MODEL_IDS = DEF_MODEL_IDS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [FREE_ID_W-1:0] free_id,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [GRANTED_W-1:0] granted_id,
    output logic [COUNT_W-1:0]   free_count
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    fla_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    fla_datapath #(.MODEL_IDS(MODEL_IDS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (req_type),
        .free_id    (free_id),
        .done       (done),
        .status     (status),
        .granted_id (granted_id),
        .free_count (free_count)
    );

endmodule

/* design/fla_checker.sv */
module fla_checker
    import fla_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [STATUS_W-1:0]  status,
    input logic [GRANTED_W-1:0] granted_id,
    input logic [COUNT_W-1:0]   free_count
);

    // A result only follows a cycle in which the block was working on an item.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // An accepted item makes the block busy and no result appears right away.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not hold busy off the result");

    // Only a successful allocation hands out an identifier.
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_id == '0))
        else $error("refused request reported an identifier");

    // An empty pool leaves no free identifiers.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (free_count == '0))
        else $error("empty status with a nonzero free count");

endmodule

bind model_id_free_list_allocator_top fla_checker u_fla_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .granted_id (granted_id),
    .free_count (free_count)
);
